// ===== hw/rtl/hsps_pkg.sv =====
// Shared types, constants and helper functions for the SPS picture-size parser.
// No dependencies; every other file of the block refers to it by scoped names.
package hsps_pkg;

  localparam int VAL_W = 17;
  typedef logic [VAL_W-1:0] val_t;

  localparam logic [4:0] MAX_LEAD_ZEROS = 5'd15;
  localparam val_t       MAX_POC_CYCLE  = 17'd255;
  localparam logic [4:0] NAL_SPS        = 5'd7;
  localparam logic [7:0] START_BYTE     = 8'h01;

  localparam logic [3:0] ST_OK     = 4'd0;
  localparam logic [3:0] ST_NO_SPS = 4'd1;
  localparam logic [3:0] ST_ID     = 4'd2;
  localparam logic [3:0] ST_CHROMA = 4'd3;
  localparam logic [3:0] ST_PLANES = 4'd4;
  localparam logic [3:0] ST_DEPTH  = 4'd5;
  localparam logic [3:0] ST_FRAME  = 4'd6;
  localparam logic [3:0] ST_LSB    = 4'd7;
  localparam logic [3:0] ST_POC    = 4'd8;
  localparam logic [3:0] ST_CYCLE  = 4'd9;
  localparam logic [3:0] ST_REFS   = 4'd10;
  localparam logic [3:0] ST_LONG   = 4'd11;
  localparam logic [3:0] ST_TRUNC  = 4'd12;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_HEADER,
    PH_SPS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_HOLD
  } ctrl_t;

  typedef enum logic [4:0] {
    S_PROFILE, S_FLAGS, S_LEVEL, S_ID, S_CHROMA, S_PLANES, S_DEPTH_L,
    S_DEPTH_C, S_BYPASS, S_SCALE_FLAG, S_LIST_FLAG, S_DELTA, S_FRAME_NUM,
    S_POC_TYPE, S_POC_LSB, S_DELTA_ZERO, S_NONREF, S_TOPBOT, S_CYCLE,
    S_OFFSET, S_REFS, S_GAPS, S_WIDTH, S_HEIGHT
  } step_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [19:0] pixel_width;
    logic [19:0] pixel_height;
    logic [3:0]  status;
  } out_word_t;

  typedef struct packed {
    logic bit_vld;
    logic bit_val;
    logic restart;
  } fld_cmd_t;

  typedef struct packed {
    logic        done;
    logic [3:0]  status;
    logic [15:0] w_mbs;
    logic [15:0] h_mbs;
  } fld_res_t;

  function automatic logic [3:0] fixed_width(input step_t s);
    logic [3:0] w;
    unique case (s)
      S_PROFILE, S_FLAGS, S_LEVEL: w = 4'd8;
      S_PLANES, S_BYPASS, S_SCALE_FLAG, S_LIST_FLAG, S_DELTA_ZERO, S_GAPS: w = 4'd1;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic is_high(input logic [7:0] p);
    return (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244) ||
           (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd118) ||
           (p == 8'd128);
  endfunction

  function automatic logic [15:0] sat_mbs(input val_t v);
    return (v >= 17'd65535) ? 16'hFFFF : (v[15:0] + 16'd1);
  endfunction

endpackage

// ===== hw/rtl/hsps_field.sv =====
// Bit-serial SPS field decoder: fixed fields and Exp-Golomb codes, one bit a cycle while bit_vld is set.
// Depends on hsps_pkg.
module hsps_field (
  input  logic              clk,
  input  logic              rst_n,
  input  hsps_pkg::fld_cmd_t cmd,
  output hsps_pkg::fld_res_t res
);

  hsps_pkg::step_t step_r, step_nxt, go_step;
  logic [3:0]  fixed_r, fixed_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [15:0] suf_r, suf_nxt, suf_sh;
  logic [4:0]  sleft_r, sleft_nxt;
  logic        insuf_r, insuf_nxt;
  logic        high_r, high_nxt;
  logic        c444_r, c444_nxt;
  logic [7:0]  poc_r, poc_nxt, poc_dec;
  logic [15:0] width_r, width_nxt;
  logic [3:0]  list_r, list_nxt, list_inc;
  logic [6:0]  coef_r, coef_nxt;
  logic [7:0]  scale_r, scale_nxt, d8, sum8;
  logic        cmplt, go, nl;
  hsps_pkg::val_t val;
  logic        done;
  logic [3:0]  status;

  always_comb begin
    step_nxt  = step_r;
    fixed_nxt = fixed_r;
    lz_nxt    = lz_r;
    suf_nxt   = suf_r;
    sleft_nxt = sleft_r;
    insuf_nxt = insuf_r;
    high_nxt  = high_r;
    c444_nxt  = c444_r;
    poc_nxt   = poc_r;
    width_nxt = width_r;
    list_nxt  = list_r;
    coef_nxt  = coef_r;
    scale_nxt = scale_r;
    cmplt     = 1'b0;
    go        = 1'b0;
    nl        = 1'b0;
    go_step   = step_r;
    val       = '0;
    done      = 1'b0;
    status    = hsps_pkg::ST_OK;
    suf_sh    = {suf_r[14:0], cmd.bit_val};

    if (cmd.bit_vld) begin
      if (fixed_r != 4'd0) begin
        suf_nxt   = suf_sh;
        fixed_nxt = fixed_r - 4'd1;
        if (fixed_r == 4'd1) begin
          cmplt = 1'b1;
          val   = {1'b0, suf_sh};
        end
      end else if (!insuf_r) begin
        if (!cmd.bit_val) begin
          if (lz_r >= hsps_pkg::MAX_LEAD_ZEROS) begin
            done   = 1'b1;
            status = hsps_pkg::ST_LONG;
          end else begin
            lz_nxt = lz_r + 5'd1;
          end
        end else if (lz_r == 5'd0) begin
          cmplt = 1'b1;
        end else begin
          insuf_nxt = 1'b1;
          sleft_nxt = lz_r;
          suf_nxt   = '0;
        end
      end else begin
        suf_nxt   = suf_sh;
        sleft_nxt = sleft_r - 5'd1;
        if (sleft_r == 5'd1) begin
          cmplt = 1'b1;
          val   = ((hsps_pkg::val_t'(1) << lz_r) - hsps_pkg::val_t'(1)) + {1'b0, suf_sh};
        end
      end
    end

    // signed delta, low byte only
    d8       = val[0] ? (val[8:1] + 8'd1) : (8'd0 - val[8:1]);
    sum8     = scale_r + d8;
    list_inc = list_r + 4'd1;
    poc_dec  = (poc_r != 8'd0) ? (poc_r - 8'd1) : 8'd0;

    if (cmplt) begin
      unique case (step_r)
        hsps_pkg::S_PROFILE: begin
          high_nxt = hsps_pkg::is_high(val[7:0]);
          go = 1'b1; go_step = hsps_pkg::S_FLAGS;
        end
        hsps_pkg::S_FLAGS: begin go = 1'b1; go_step = hsps_pkg::S_LEVEL; end
        hsps_pkg::S_LEVEL: begin go = 1'b1; go_step = hsps_pkg::S_ID; end
        hsps_pkg::S_ID: begin
          if (val >= 17'd32) begin
            done = 1'b1; status = hsps_pkg::ST_ID;
          end else begin
            go = 1'b1;
            go_step = high_r ? hsps_pkg::S_CHROMA : hsps_pkg::S_FRAME_NUM;
          end
        end
        hsps_pkg::S_CHROMA: begin
          if (val > 17'd3) begin
            done = 1'b1; status = hsps_pkg::ST_CHROMA;
          end else begin
            c444_nxt = (val == 17'd3);
            go = 1'b1;
            go_step = (val == 17'd3) ? hsps_pkg::S_PLANES : hsps_pkg::S_DEPTH_L;
          end
        end
        hsps_pkg::S_PLANES: begin
          if (val != 17'd0) begin
            done = 1'b1; status = hsps_pkg::ST_PLANES;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_DEPTH_L;
          end
        end
        hsps_pkg::S_DEPTH_L: begin
          if (val > 17'd6) begin
            done = 1'b1; status = hsps_pkg::ST_DEPTH;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_DEPTH_C;
          end
        end
        hsps_pkg::S_DEPTH_C: begin
          if (val > 17'd6) begin
            done = 1'b1; status = hsps_pkg::ST_DEPTH;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_BYPASS;
          end
        end
        hsps_pkg::S_BYPASS: begin go = 1'b1; go_step = hsps_pkg::S_SCALE_FLAG; end
        hsps_pkg::S_SCALE_FLAG: begin
          list_nxt = 4'd0;
          go = 1'b1;
          go_step = val[0] ? hsps_pkg::S_LIST_FLAG : hsps_pkg::S_FRAME_NUM;
        end
        hsps_pkg::S_LIST_FLAG: begin
          if (val[0]) begin
            scale_nxt = 8'd8;
            coef_nxt  = (list_r < 4'd6) ? 7'd16 : 7'd64;
            go = 1'b1; go_step = hsps_pkg::S_DELTA;
          end else begin
            nl = 1'b1;
          end
        end
        hsps_pkg::S_DELTA: begin
          if (sum8 == 8'd0) begin
            nl = 1'b1;
          end else begin
            scale_nxt = sum8;
            coef_nxt  = coef_r - 7'd1;
            if (coef_r == 7'd1) begin
              nl = 1'b1;
            end else begin
              go = 1'b1; go_step = hsps_pkg::S_DELTA;
            end
          end
        end
        hsps_pkg::S_FRAME_NUM: begin
          if (val > 17'd12) begin
            done = 1'b1; status = hsps_pkg::ST_FRAME;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_POC_TYPE;
          end
        end
        hsps_pkg::S_POC_TYPE: begin
          if (val > 17'd2) begin
            done = 1'b1; status = hsps_pkg::ST_POC;
          end else begin
            go = 1'b1;
            go_step = (val == 17'd0) ? hsps_pkg::S_POC_LSB :
                      ((val == 17'd1) ? hsps_pkg::S_DELTA_ZERO : hsps_pkg::S_REFS);
          end
        end
        hsps_pkg::S_POC_LSB: begin
          if (val > 17'd12) begin
            done = 1'b1; status = hsps_pkg::ST_LSB;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_REFS;
          end
        end
        hsps_pkg::S_DELTA_ZERO: begin go = 1'b1; go_step = hsps_pkg::S_NONREF; end
        hsps_pkg::S_NONREF: begin go = 1'b1; go_step = hsps_pkg::S_TOPBOT; end
        hsps_pkg::S_TOPBOT: begin go = 1'b1; go_step = hsps_pkg::S_CYCLE; end
        hsps_pkg::S_CYCLE: begin
          if (val > hsps_pkg::MAX_POC_CYCLE) begin
            done = 1'b1; status = hsps_pkg::ST_CYCLE;
          end else begin
            poc_nxt = val[7:0];
            go = 1'b1;
            go_step = (val == 17'd0) ? hsps_pkg::S_REFS : hsps_pkg::S_OFFSET;
          end
        end
        hsps_pkg::S_OFFSET: begin
          poc_nxt = poc_dec;
          go = 1'b1;
          go_step = (poc_dec == 8'd0) ? hsps_pkg::S_REFS : hsps_pkg::S_OFFSET;
        end
        hsps_pkg::S_REFS: begin
          if (val > 17'd16) begin
            done = 1'b1; status = hsps_pkg::ST_REFS;
          end else begin
            go = 1'b1; go_step = hsps_pkg::S_GAPS;
          end
        end
        hsps_pkg::S_GAPS: begin go = 1'b1; go_step = hsps_pkg::S_WIDTH; end
        hsps_pkg::S_WIDTH: begin
          width_nxt = hsps_pkg::sat_mbs(val);
          go = 1'b1; go_step = hsps_pkg::S_HEIGHT;
        end
        hsps_pkg::S_HEIGHT: begin
          done = 1'b1; status = hsps_pkg::ST_OK;
        end
        default: begin
          done = 1'b1; status = hsps_pkg::ST_TRUNC;
        end
      endcase
    end

    // end of a scaling list
    if (nl) begin
      list_nxt = list_inc;
      go = 1'b1;
      go_step = (list_inc >= (c444_r ? 4'd12 : 4'd8)) ? hsps_pkg::S_FRAME_NUM :
                                                        hsps_pkg::S_LIST_FLAG;
    end

    if (go) begin
      step_nxt  = go_step;
      fixed_nxt = hsps_pkg::fixed_width(go_step);
      suf_nxt   = '0;
      lz_nxt    = '0;
      sleft_nxt = '0;
      insuf_nxt = 1'b0;
    end
  end

  assign res.done   = done;
  assign res.status = status;
  assign res.w_mbs  = width_r;
  assign res.h_mbs  = hsps_pkg::sat_mbs(val);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      step_r  <= hsps_pkg::S_PROFILE;
      fixed_r <= hsps_pkg::fixed_width(hsps_pkg::S_PROFILE);
      lz_r    <= '0;
      suf_r   <= '0;
      sleft_r <= '0;
      insuf_r <= 1'b0;
      high_r  <= 1'b0;
      c444_r  <= 1'b0;
      poc_r   <= '0;
      width_r <= '0;
      list_r  <= '0;
      coef_r  <= '0;
      scale_r <= '0;
    end else begin
      step_r  <= step_nxt;
      fixed_r <= fixed_nxt;
      lz_r    <= lz_nxt;
      suf_r   <= suf_nxt;
      sleft_r <= sleft_nxt;
      insuf_r <= insuf_nxt;
      high_r  <= high_nxt;
      c444_r  <= c444_nxt;
      poc_r   <= poc_nxt;
      width_r <= width_nxt;
      list_r  <= list_nxt;
      coef_r  <= coef_nxt;
      scale_r <= scale_nxt;
    end
  end

endmodule

// ===== hw/rtl/hsps_ctrl.sv =====
// Byte framer: start-code scan, NAL header check, bit shift register and result hold.
// Depends on hsps_pkg; drives hsps_field one bit per cycle while in the shift state.
module hsps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsps_pkg::in_word_t  in_data,
  output hsps_pkg::fld_cmd_t  cmd,
  input  hsps_pkg::fld_res_t  fres,
  output logic                res_vld,
  output hsps_pkg::out_word_t res_word,
  input  logic                take
);

  hsps_pkg::ctrl_t     state_r, state_nxt;
  hsps_pkg::phase_t    phase_r, phase_nxt;
  logic [1:0]          zrun_r, zrun_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic                fin_r, fin_nxt;
  hsps_pkg::out_word_t res_r, res_nxt;
  logic                last_bit;

  assign last_bit = (cnt_r == 3'd0);
  assign in_stall = (state_r != hsps_pkg::C_IDLE);
  assign res_vld  = (state_r == hsps_pkg::C_HOLD);
  assign res_word = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsps_pkg::C_IDLE: begin
        if (in_valid) begin
          if (phase_r == hsps_pkg::PH_SPS) begin
            state_nxt = hsps_pkg::C_SHIFT;
          end else if (in_data.final_byte && phase_r != hsps_pkg::PH_DONE) begin
            state_nxt = hsps_pkg::C_HOLD;
          end
        end
      end
      hsps_pkg::C_SHIFT: begin
        if (fres.done || (last_bit && fin_r)) begin
          state_nxt = hsps_pkg::C_HOLD;
        end else if (last_bit) begin
          state_nxt = hsps_pkg::C_IDLE;
        end
      end
      hsps_pkg::C_HOLD: begin
        if (take) state_nxt = hsps_pkg::C_IDLE;
      end
      default: state_nxt = hsps_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    zrun_nxt    = zrun_r;
    byte_nxt    = byte_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    res_nxt     = res_r;
    cmd.bit_vld = 1'b0;
    cmd.bit_val = byte_r[7];
    cmd.restart = 1'b0;

    unique case (state_r)
      hsps_pkg::C_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.stream_byte;
          fin_nxt  = in_data.final_byte;
          cnt_nxt  = 3'd7;
          unique case (phase_r)
            hsps_pkg::PH_SCAN: begin
              if (in_data.stream_byte == hsps_pkg::START_BYTE && zrun_r == 2'd3) begin
                phase_nxt = hsps_pkg::PH_HEADER;
              end else if (in_data.stream_byte == 8'd0) begin
                zrun_nxt = (zrun_r == 2'd3) ? 2'd3 : (zrun_r + 2'd1);
              end else begin
                zrun_nxt = 2'd0;
              end
            end
            hsps_pkg::PH_HEADER: begin
              if (in_data.stream_byte[4:0] == hsps_pkg::NAL_SPS) begin
                phase_nxt   = hsps_pkg::PH_SPS;
                cmd.restart = 1'b1;
              end else begin
                phase_nxt = hsps_pkg::PH_SCAN;
                zrun_nxt  = (in_data.stream_byte == 8'd0) ? 2'd1 : 2'd0;
              end
            end
            default: ;
          endcase
          if (in_data.final_byte && phase_r != hsps_pkg::PH_SPS) begin
            if (phase_r != hsps_pkg::PH_DONE) begin
              res_nxt.pixel_width  = '0;
              res_nxt.pixel_height = '0;
              res_nxt.status = (phase_nxt == hsps_pkg::PH_SPS) ? hsps_pkg::ST_TRUNC :
                                                                 hsps_pkg::ST_NO_SPS;
            end
            phase_nxt   = hsps_pkg::PH_SCAN;
            zrun_nxt    = 2'd0;
            cmd.restart = 1'b1;
          end
        end
      end
      hsps_pkg::C_SHIFT: begin
        cmd.bit_vld = 1'b1;
        byte_nxt    = {byte_r[6:0], 1'b0};
        cnt_nxt     = cnt_r - 3'd1;
        if (fres.done) begin
          phase_nxt = hsps_pkg::PH_DONE;
          res_nxt.status = fres.status;
          if (fres.status == hsps_pkg::ST_OK) begin
            res_nxt.pixel_width  = {fres.w_mbs, 4'h0};
            res_nxt.pixel_height = {fres.h_mbs, 4'h0};
          end else begin
            res_nxt.pixel_width  = '0;
            res_nxt.pixel_height = '0;
          end
        end else if (last_bit && fin_r) begin
          res_nxt.pixel_width  = '0;
          res_nxt.pixel_height = '0;
          res_nxt.status       = hsps_pkg::ST_TRUNC;
        end
        if ((fres.done || last_bit) && fin_r) begin
          phase_nxt   = hsps_pkg::PH_SCAN;
          zrun_nxt    = 2'd0;
          cmd.restart = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsps_pkg::C_IDLE;
      phase_r <= hsps_pkg::PH_SCAN;
      zrun_r  <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      zrun_r  <= zrun_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== hw/rtl/h264_sps_picture_size_parser_top.sv =====
// Top level of the H.264 SPS picture-size parser: framer, field decoder, output register.
// Depends on hsps_pkg, hsps_ctrl and hsps_field.

// Takes an Annex B byte stream one word per accepted byte and returns one result word
// per buffer (the buffer ends at final_byte): picture width and height in pixels and a
// status code. Bytes outside an SPS, but for a final byte that owes a result, do not
// stall the input. Bytes inside an SPS go through an 8-bit shift register into the
// Exp-Golomb field decoder at one bit per cycle, and the input stalls while a byte is
// being shifted. The byte that ends the SPS stops shifting at the bit that completes
// it, or after its last bit when the buffer ends truncated, and then waits in the
// result hold while the output register is still occupied and stalled. A final byte
// outside an SPS that owes a result waits in the result hold the same way. The output
// register lets the next byte be taken while a result waits on the output side.
module h264_sps_picture_size_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsps_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsps_pkg::out_word_t out_data
);

  hsps_pkg::fld_cmd_t  cmd;
  hsps_pkg::fld_res_t  fres;
  logic                res_vld;
  hsps_pkg::out_word_t res_word;
  logic                take;
  logic                out_valid_r, out_valid_nxt;
  hsps_pkg::out_word_t out_data_r;

  hsps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd      (cmd),
    .fres     (fres),
    .res_vld  (res_vld),
    .res_word (res_word),
    .take     (take)
  );

  hsps_field u_field (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (fres)
  );

  assign take = res_vld && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/hsps_check.sv =====
// Port-level checker for the SPS picture-size parser, bound to the top level.
// Depends on hsps_pkg and h264_sps_picture_size_parser_top.
module hsps_check (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hsps_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hsps_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hsps_pkg::ST_OK |->
      out_data.pixel_width != 20'd0 && out_data.pixel_height != 20'd0)
    else $error("ok result with zero size");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != hsps_pkg::ST_OK |->
      out_data.pixel_width == 20'd0 && out_data.pixel_height == 20'd0)
    else $error("error result with nonzero size");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= hsps_pkg::ST_TRUNC)
    else $error("status code out of range");

  a_size_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_width[3:0] == 4'h0 && out_data.pixel_height[3:0] == 4'h0)
    else $error("size not a macroblock multiple");

endmodule

bind h264_sps_picture_size_parser_top hsps_check u_check (.*);
